// ===== src/s2da_pkg.sv =====
// shared types and constants for the signed integer to decimal text block
// no dependencies

package s2da_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int unsigned IDX_W      = $clog2(NUM_DIGITS);

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic busy;
  } conv_stat_t;

  typedef struct packed {
    logic                start;
    logic [VALUE_W-1:0]  mag;
  } conv_ctrl_t;

endpackage

// ===== src/s2da_dabble.sv =====
// iterative binary to bcd converter, shift-and-add-3, one bit per cycle
// depends on s2da_pkg

module s2da_dabble (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  s2da_pkg::conv_ctrl_t    ctrl_i,
  output s2da_pkg::conv_stat_t    stat_o,
  output logic [s2da_pkg::BCD_W-1:0] bcd_o
);
  import s2da_pkg::*;

  localparam int unsigned CNT_W = $clog2(VALUE_W);

  logic [VALUE_W-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]   bcd_q, bcd_d, bcd_adj;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               run_q, run_d;

  // add three to every digit that is five or more, all digits in parallel
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    run_d = run_q;
    if (ctrl_i.start) begin
      // first step folded into the load: nothing to adjust on a cleared bcd
      bcd_d = {{(BCD_W-1){1'b0}}, ctrl_i.mag[VALUE_W-1]};
      bin_d = {ctrl_i.mag[VALUE_W-2:0], 1'b0};
      cnt_d = CNT_W'(1);
      run_d = 1'b1;
    end else if (run_q) begin
      bcd_d = {bcd_adj[BCD_W-2:0], bin_q[VALUE_W-1]};
      bin_d = {bin_q[VALUE_W-2:0], 1'b0};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(VALUE_W - 1)) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign stat_o.busy = run_q;
  assign bcd_o       = bcd_q;

endmodule

// ===== src/signed_int_to_decimal_ascii.sv =====
// top level: signed 32-bit integer in, decimal ascii characters out
// depends on s2da_pkg and s2da_dabble
//
//  channel  | dir | payload                        | framing
//  ---------+-----+--------------------------------+---------------------------
//  s_axis   | in  | tdata[31:0] value (signed)     | one transfer per number
//  m_axis   | out | tdata[7:0] character           | tlast = last_char
//
// sequence: the value is taken, then 31 further double-dabble steps in the
// shared adjust-and-shift unit, then the leading digit is located, then
// one character per cycle, 1 to 11 chars per number, while the sink keeps
// tready high
// s_axis_tready is high only while idle; a stalled m_axis transfer holds
// the character and the block simply waits
// reset clears the sequencer and the conversion counter; no state is kept
// from one number to the next

module signed_int_to_decimal_ascii (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [s2da_pkg::VALUE_W-1:0]  s_axis_tdata,   // [31:0] value
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [s2da_pkg::CHAR_W-1:0]   m_axis_tdata,   // [7:0] character
  output logic                          m_axis_tlast    // last_char
);
  import s2da_pkg::*;

  state_e             state_q, state_d;
  logic               sign_q, sign_d;     // minus sign still to be sent
  logic [IDX_W-1:0]   idx_q, idx_d;       // digit being sent

  conv_ctrl_t         conv_ctrl;
  conv_stat_t         conv_stat;
  logic [BCD_W-1:0]   bcd;
  logic [IDX_W-1:0]   lead_idx;
  logic [DIGIT_W-1:0] cur_digit;

  // leading nonzero digit, or the units digit when the value is zero
  always_comb begin
    lead_idx = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] != '0) begin
        lead_idx = IDX_W'(i);
      end
    end
  end

  assign cur_digit = bcd[idx_q*DIGIT_W +: DIGIT_W];

  s2da_dabble u_dabble (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (conv_ctrl),
    .stat_o (conv_stat),
    .bcd_o  (bcd)
  );

  always_comb begin
    state_d         = state_q;
    sign_d          = sign_q;
    idx_d           = idx_q;
    s_axis_tready   = 1'b0;
    m_axis_tvalid   = 1'b0;
    conv_ctrl.start = 1'b0;
    // two's complement magnitude; the most negative value wraps to 2^31,
    // which still fits the unsigned 32-bit word
    conv_ctrl.mag   = s_axis_tdata[VALUE_W-1] ? (VALUE_W'(0) - s_axis_tdata)
                                              : s_axis_tdata;
    m_axis_tdata    = CHAR_ZERO + CHAR_W'(cur_digit);
    m_axis_tlast    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          conv_ctrl.start = 1'b1;
          sign_d          = s_axis_tdata[VALUE_W-1];
          state_d         = ST_CONV;
        end
      end
      ST_CONV: begin
        if (!conv_stat.busy) begin
          idx_d   = lead_idx;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        m_axis_tvalid = 1'b1;
        if (sign_q) begin
          m_axis_tdata = CHAR_MINUS;
        end
        m_axis_tlast = !sign_q && (idx_q == '0);
        if (m_axis_tready) begin
          if (sign_q) begin
            sign_d = 1'b0;
          end else if (idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q - IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sign_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      sign_q  <= sign_d;
      idx_q   <= idx_d;
    end
  end

endmodule

// ===== src/s2da_checker.sv =====
// port-level checks for the signed integer to decimal text block
// depends on s2da_pkg; bound to signed_int_to_decimal_ascii

module s2da_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [s2da_pkg::CHAR_W-1:0]   m_axis_tdata,
  input logic                          m_axis_tlast
);
  import s2da_pkg::*;

  // one number at a time: never taking input while characters are shown
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while output valid");

  // an accepted number closes the input side on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready right after a transfer");

  // the run ends with its last transfer
  a_end_of_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
    else $error("output still valid after last character");

  // stalled character holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled character changed");

  // last character is always a digit, never the minus sign
  a_last_is_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata != CHAR_MINUS))
    else $error("minus sign marked as last character");

endmodule

bind signed_int_to_decimal_ascii s2da_checker u_s2da_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
